### rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// Bit array store package
// Shared opcodes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 3;
  localparam int BIDX_W   = INDEX_W - OFF_W;

  localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_BIT   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CLR_BIT   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_BIT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_EXTRACT   = 3'd4;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_BIT_RD  = 7'b0000100,
    ST_BIT_MOD = 7'b0001000,
    ST_X_RD    = 7'b0010000,
    ST_X_DAT   = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### rtl/bas_ram.sv
// ----------------------------------------------------------------------------
// Bit array store RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bas_shift_unit.sv
// ----------------------------------------------------------------------------
// Bit array store shift unit
// Funnel shift of two bytes by a bit offset, and the MSB-first bit mask.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_shift_unit (
  input  wire logic [bas_pkg::BYTE_W-1:0] hi,
  input  wire logic [bas_pkg::BYTE_W-1:0] lo,
  input  wire logic [bas_pkg::OFF_W-1:0]  off,
  output logic      [bas_pkg::BYTE_W-1:0] aligned,
  output logic      [bas_pkg::BYTE_W-1:0] mask
);

  logic [2*bas_pkg::BYTE_W-1:0] funnel;

  assign funnel  = {hi, lo} << off;
  assign aligned = funnel[2*bas_pkg::BYTE_W-1:bas_pkg::BYTE_W];
  assign mask    = 8'h80 >> off;

endmodule

`default_nettype wire

### rtl/bit_array_store.sv
// ----------------------------------------------------------------------------
// Bit array store
// Bit vector of BYTES bytes with clear-all, test-and-set, test-and-clear,
// read and unaligned byte extract.
// ----------------------------------------------------------------------------
// After reset the block sweeps the store to zero before it takes an item;
// clear-all repeats that sweep and then offers a result. Set, clear and
// read go through a store read, a modify step and the result state; a bit
// past the end of the store goes straight to the result. An unused opcode
// also gives a result, and an extract of zero bytes gives none. Each
// extract byte needs a read of the store RAM, whose read data is registered,
// and its own transfer; the first byte needs one more read.
// Only one item is in work at a time; a result waiting on out_stall holds
// off the next input.
`default_nettype none

module bit_array_store #(
  parameter int BYTES       = 64,
  parameter int MAX_EXTRACT = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bas_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [bas_pkg::INDEX_W-1:0]  bit_pos,
  input  wire logic [bas_pkg::COUNT_W-1:0]  byte_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              old_bit,
  output logic      [bas_pkg::BYTE_W-1:0]   data_byte,
  output logic                              last
);

  localparam int AW = $clog2(BYTES);
  localparam int PW = ((AW > bas_pkg::COUNT_W) ? AW : bas_pkg::COUNT_W) + 1;

  bas_pkg::state_t state, state_next;

  logic [bas_pkg::OPCODE_W-1:0] op;
  logic [bas_pkg::BIDX_W-1:0]   bidx;
  logic [bas_pkg::OFF_W-1:0]    off;
  logic [bas_pkg::COUNT_W-1:0]  rem;
  logic [PW-1:0]                ptr;
  logic                         first;
  logic                         oob;
  logic                         pend;
  logic [AW-1:0]                clr_addr;
  logic [bas_pkg::BYTE_W-1:0]   prev;

  logic                         in_xfer;
  logic                         out_xfer;
  logic                         in_range;
  logic                         clr_done;
  logic [bas_pkg::COUNT_W-1:0]  sat_count;
  logic [bas_pkg::BYTE_W-1:0]   cur;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [bas_pkg::BYTE_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [bas_pkg::BYTE_W-1:0]   ram_rdata;

  logic [bas_pkg::BYTE_W-1:0]   sh_hi;
  logic [bas_pkg::BYTE_W-1:0]   sh_lo;
  logic [bas_pkg::BYTE_W-1:0]   sh_aligned;
  logic [bas_pkg::BYTE_W-1:0]   sh_mask;

  assign in_stall  = (state != bas_pkg::ST_IDLE);
  assign out_valid = (state == bas_pkg::ST_OUT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  assign in_range  = PW'(bit_pos[bas_pkg::INDEX_W-1:bas_pkg::OFF_W]) < PW'(BYTES);
  assign sat_count = (byte_count > bas_pkg::COUNT_W'(MAX_EXTRACT)) ?
                     bas_pkg::COUNT_W'(MAX_EXTRACT) : byte_count;
  assign clr_done  = (clr_addr == AW'(BYTES - 1));
  assign cur       = oob ? '0 : ram_rdata;

  assign ram_we    = (state == bas_pkg::ST_CLEAR) ||
                     ((state == bas_pkg::ST_BIT_MOD) &&
                      ((op == bas_pkg::OP_SET_BIT) || (op == bas_pkg::OP_CLR_BIT)));
  assign ram_waddr = (state == bas_pkg::ST_CLEAR) ? clr_addr : AW'(bidx);
  assign ram_wdata = (state == bas_pkg::ST_CLEAR) ? '0 :
                     (op == bas_pkg::OP_SET_BIT) ? (ram_rdata | sh_mask) :
                     (ram_rdata & ~sh_mask);
  assign ram_raddr = (state == bas_pkg::ST_BIT_RD) ? AW'(bidx) : ptr[AW-1:0];

  assign sh_hi = (state == bas_pkg::ST_X_DAT) ? prev : ram_rdata;
  assign sh_lo = (state == bas_pkg::ST_X_DAT) ? cur : '0;

  bas_ram #(
    .WIDTH (bas_pkg::BYTE_W),
    .DEPTH (BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bas_shift_unit u_shift (
    .hi      (sh_hi),
    .lo      (sh_lo),
    .off     (off),
    .aligned (sh_aligned),
    .mask    (sh_mask)
  );

  always_comb begin
    state_next = state;
    case (state)
      bas_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_next = pend ? bas_pkg::ST_OUT : bas_pkg::ST_IDLE;
        end
      end
      bas_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (opcode)
            bas_pkg::OP_CLEAR_ALL: state_next = bas_pkg::ST_CLEAR;
            bas_pkg::OP_SET_BIT,
            bas_pkg::OP_CLR_BIT,
            bas_pkg::OP_READ_BIT: begin
              state_next = in_range ? bas_pkg::ST_BIT_RD : bas_pkg::ST_OUT;
            end
            bas_pkg::OP_EXTRACT: begin
              state_next = (sat_count == '0) ? bas_pkg::ST_IDLE : bas_pkg::ST_X_RD;
            end
            default: state_next = bas_pkg::ST_OUT;
          endcase
        end
      end
      bas_pkg::ST_BIT_RD:  state_next = bas_pkg::ST_BIT_MOD;
      bas_pkg::ST_BIT_MOD: state_next = bas_pkg::ST_OUT;
      bas_pkg::ST_X_RD:    state_next = bas_pkg::ST_X_DAT;
      bas_pkg::ST_X_DAT:   state_next = first ? bas_pkg::ST_X_RD : bas_pkg::ST_OUT;
      bas_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_next = ((op == bas_pkg::OP_EXTRACT) && (rem != '0)) ?
                       bas_pkg::ST_X_RD : bas_pkg::ST_IDLE;
        end
      end
      default: state_next = bas_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bas_pkg::ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bas_pkg::ST_CLEAR) begin
        clr_addr <= clr_done ? '0 : clr_addr + AW'(1);
        if (clr_done) begin
          pend <= 1'b0;
        end
      end
      if (in_xfer && (opcode == bas_pkg::OP_CLEAR_ALL)) begin
        pend <= 1'b1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    case (state)
      bas_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op        <= opcode;
          bidx      <= bit_pos[bas_pkg::INDEX_W-1:bas_pkg::OFF_W];
          off       <= bit_pos[bas_pkg::OFF_W-1:0];
          rem       <= sat_count;
          ptr       <= PW'(bit_pos[bas_pkg::INDEX_W-1:bas_pkg::OFF_W]);
          first     <= 1'b1;
          old_bit   <= 1'b0;
          data_byte <= '0;
          last      <= 1'b1;
        end
      end
      bas_pkg::ST_BIT_MOD: begin
        old_bit <= sh_aligned[bas_pkg::BYTE_W-1];
      end
      bas_pkg::ST_X_RD: begin
        oob <= (ptr >= PW'(BYTES));
        ptr <= ptr + PW'(1);
      end
      bas_pkg::ST_X_DAT: begin
        prev  <= cur;
        first <= 1'b0;
        if (!first) begin
          old_bit   <= 1'b0;
          data_byte <= sh_aligned;
          last      <= (rem == bas_pkg::COUNT_W'(1));
          rem       <= rem - bas_pkg::COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bas_checker.sv
// ----------------------------------------------------------------------------
// Bit array store checker
// Port-level checks on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         old_bit,
  input wire logic [bas_pkg::BYTE_W-1:0]   data_byte,
  input wire logic                         last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_one_item: assert property (@(posedge clk) out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(data_byte) && $stable(old_bit) && $stable(last)))
    else $error("stalled result changed");

  a_bit_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && old_bit) |-> ((data_byte == '0) && last))
    else $error("bit result carries extract data");

endmodule

bind bit_array_store bas_checker u_bas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .old_bit   (old_bit),
  .data_byte (data_byte),
  .last      (last)
);

`default_nettype wire
